// ----- rtl/lap3_pkg.sv -----
// ----------------------------------------------------------------------------
// Laplacian 3x3 edge filter package
// Shared widths, constants and types of the Laplacian edge filter.
// ----------------------------------------------------------------------------
package lap3_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 1024;

    localparam int unsigned PIX_W        = 8;
    localparam int unsigned WIDTH_REG_W  = 11;
    localparam int unsigned HEIGHT_REG_W = 12;
    localparam int unsigned ROW_W        = 12;
    localparam int unsigned CCOL_W       = 10;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 12;
    localparam int unsigned DIM_W        = 13;
    localparam int unsigned SUM_W        = 14;

    localparam int unsigned WIDTH_RESET  = 1024;
    localparam int unsigned HEIGHT_RESET = 1024;
    localparam int unsigned HEIGHT_MAX   = 4095;
    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned SUM_OFFSET   = 128;
    localparam int unsigned PIX_MAX      = 255;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

endpackage

// ----- rtl/laplacian_3x3_edge_filter_core.sv -----
// ----------------------------------------------------------------------------
// Laplacian 3x3 edge filter core
// Streams grey pixels in raster order and emits clamped Laplacian values for
// interior pixels together with the center coordinates.
// ----------------------------------------------------------------------------
// The core takes one pixel transaction per clock cycle unless a result held
// by back-pressure stalls an input stage that holds a result pixel. A pixel
// is held in the input stage while the two line stores (one read and one
// write port each, read data registered) deliver the column above it; the
// nine-tap sum, the offset of 128 and the clamp are done on the way from the
// input stage into the result register, so each result passes through both
// registers. When the pixel at row r and column c arrives, with r and c both
// at least two, a result for the center at row r-1 and column c-1 follows;
// border pixels give none. Line stores need no clearing pass after reset. A
// write to the width or height register restarts the frame at row zero and
// column zero; write configuration only while the core is idle.
module laplacian_3x3_edge_filter_core
    import lap3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [PIX_W-1:0]        i_pixel_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [PIX_W-1:0]        o_edge_value,
    output logic [ROW_W-1:0]        o_center_row,
    output logic [CCOL_W-1:0]       o_center_col,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        n_col;
    logic [ROW_W-1:0]        n_row;

    logic                    r_s1_valid;
    t_pix                    r_s1_pix;
    logic [COL_W-1:0]        r_s1_col;
    logic [ROW_W-1:0]        r_s1_row;
    t_pix                    r_top_rd;
    t_pix                    r_mid_rd;

    t_pix                    r_win [0:5];
    t_pix                    mem_upper [0:MAX_WIDTH-1];
    t_pix                    mem_middle [0:MAX_WIDTH-1];

    logic                    r_out_valid;
    t_pix                    r_edge;
    logic [ROW_W-1:0]        r_crow;
    logic [CCOL_W-1:0]       r_ccol;

    logic [DIM_W-1:0]        w_raw;
    logic [DIM_W-1:0]        h_raw;
    logic [DIM_W-1:0]        w_eff;
    logic [DIM_W-1:0]        h_eff;
    logic [DIM_W-1:0]        col_inc;
    logic [DIM_W-1:0]        row_inc;

    logic                    in_acc;
    logic                    cfg_acc;
    logic                    s1_produce;
    logic                    s1_adv;
    logic                    out_free;

    logic signed [SUM_W-1:0] tap_ul, tap_um, tap_ur, tap_ml, tap_mm, tap_mr;
    logic signed [SUM_W-1:0] tap_ll, tap_lm, tap_lr;
    logic signed [SUM_W-1:0] sum;
    t_pix                    edge_clamped;

    assign in_acc      = i_in_valid & o_in_ready;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    assign out_free    = ~r_out_valid | i_out_ready;
    assign s1_produce  = (r_s1_row >= ROW_W'(2)) && (r_s1_col >= COL_W'(2));
    assign s1_adv      = r_s1_valid & (~s1_produce | out_free);
    assign o_in_ready  = ~r_s1_valid | s1_adv;

    always_comb begin
        w_raw = DIM_W'(r_image_width);
        h_raw = DIM_W'(r_image_height);
        if (w_raw < DIM_W'(MIN_DIM)) begin
            w_eff = DIM_W'(MIN_DIM);
        end else if (w_raw > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        if (h_raw < DIM_W'(MIN_DIM)) begin
            h_eff = DIM_W'(MIN_DIM);
        end else if (h_raw > DIM_W'(HEIGHT_MAX)) begin
            h_eff = DIM_W'(HEIGHT_MAX);
        end else begin
            h_eff = h_raw;
        end
    end

    always_comb begin
        col_inc = DIM_W'(r_col) + DIM_W'(1);
        row_inc = DIM_W'(r_row) + DIM_W'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = ROW_W'(row_inc);
            end
        end else begin
            n_col = COL_W'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_REG_W'(WIDTH_RESET);
            r_image_height <= HEIGHT_REG_W'(HEIGHT_RESET);
            r_col          <= '0;
            r_row          <= '0;
        end else if (cfg_acc) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[WIDTH_REG_W-1:0];
                    r_col         <= '0;
                    r_row         <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                    r_col          <= '0;
                    r_row          <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_pixel_in;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_top_rd <= mem_upper[r_col];
        end
        if (s1_adv) begin
            mem_upper[r_s1_col] <= r_mid_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid_rd <= mem_middle[r_col];
        end
        if (s1_adv) begin
            mem_middle[r_s1_col] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[1] <= r_win[0];
            r_win[0] <= r_top_rd;
            r_win[3] <= r_win[2];
            r_win[2] <= r_mid_rd;
            r_win[5] <= r_win[4];
            r_win[4] <= r_s1_pix;
        end
    end

    always_comb begin
        tap_ul = $signed(SUM_W'(r_win[1]));
        tap_um = $signed(SUM_W'(r_win[0]));
        tap_ur = $signed(SUM_W'(r_top_rd));
        tap_ml = $signed(SUM_W'(r_win[3]));
        tap_mm = $signed(SUM_W'(r_win[2]));
        tap_mr = $signed(SUM_W'(r_mid_rd));
        tap_ll = $signed(SUM_W'(r_win[5]));
        tap_lm = $signed(SUM_W'(r_win[4]));
        tap_lr = $signed(SUM_W'(r_s1_pix));
        sum  = tap_ul + (tap_um <<< 2) + tap_ur
             + (tap_ml <<< 2) - (tap_mm <<< 4) - (tap_mm <<< 2) + (tap_mr <<< 2)
             + tap_ll + (tap_lm <<< 2) + tap_lr
             + $signed(SUM_W'(SUM_OFFSET));
        if (sum < $signed(SUM_W'(0))) begin
            edge_clamped = '0;
        end else if (sum > $signed(SUM_W'(PIX_MAX))) begin
            edge_clamped = PIX_W'(PIX_MAX);
        end else begin
            edge_clamped = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_produce) begin
            r_edge <= edge_clamped;
            r_crow <= r_s1_row - ROW_W'(1);
            r_ccol <= CCOL_W'(r_s1_col - COL_W'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_edge_value = r_edge;
    assign o_center_row = r_crow;
    assign o_center_col = r_ccol;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < w_eff)
        else $error("Column counter reached the effective width.");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc && (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT)
        |=> r_col == '0 && r_row == '0)
        else $error("Configuration write did not restart the frame.");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s1_produce && r_out_valid && !i_out_ready
        |=> r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row))
        else $error("Stalled input stage lost its transaction.");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("Accepted transaction did not reach the input stage.");

    a_center_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_center_row != '0 && o_center_col != '0)
        else $error("Result carries a border center.");

endmodule

// ----- bench/laplacian_3x3_edge_filter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Laplacian 3x3 edge filter core testbench
// Streams raster pixels through the core under random idling on both sides
// and checks every edge value and center coordinate against a cycle-free
// model of the line stores, the 3x3 window and the frame position.
// ----------------------------------------------------------------------------
module laplacian_3x3_edge_filter_core_tb
    import lap3_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned SETTLE_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned IDLE_PCT     = 31;
    localparam int unsigned RANDOM_ITEMS = 320;
    localparam int unsigned MAX_REPORTS  = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        t_pix              edge_val;
        logic [ROW_W-1:0]  center_row;
        logic [CCOL_W-1:0] center_col;
    } t_edge_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [PIX_W-1:0]      o_edge_value;
    logic [ROW_W-1:0]      o_center_row;
    logic [CCOL_W-1:0]     o_center_col;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_edge_result expected_edges[$];
    int unsigned  err_count = 0;
    int unsigned  cycle_count = 0;
    bit           quiet_mode = 1'b0;
    bit           hold_request = 1'b0;
    int           texture_base = 0;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    t_pix upper_line [MAX_WIDTH_DEF];
    t_pix middle_line [MAX_WIDTH_DEF];
    t_pix top_win [2];
    t_pix mid_win [2];
    t_pix bot_win [2];
    int   col_pos;
    int   row_pos;

    laplacian_3x3_edge_filter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_edge_value (o_edge_value),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $error("%s", msg);
        end
    endfunction

    function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg = data[WIDTH_REG_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = data[HEIGHT_REG_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void filter_pixel(input t_pix pix);
        int           w;
        int           h;
        int           sum;
        t_pix         above2;
        t_pix         above1;
        t_edge_result res;
        w = int'(width_reg);
        if (w < int'(MIN_DIM)) w = int'(MIN_DIM);
        if (w > int'(MAX_WIDTH_DEF)) w = int'(MAX_WIDTH_DEF);
        h = int'(height_reg);
        if (h < int'(MIN_DIM)) h = int'(MIN_DIM);
        if (h > int'(HEIGHT_MAX)) h = int'(HEIGHT_MAX);
        above2 = upper_line[col_pos];
        above1 = middle_line[col_pos];
        if (row_pos >= 2 && col_pos >= 2) begin
            sum = int'(top_win[1]) + 4 * int'(top_win[0]) + int'(above2)
                + 4 * int'(mid_win[1]) - 20 * int'(mid_win[0]) + 4 * int'(above1)
                + int'(bot_win[1]) + 4 * int'(bot_win[0]) + int'(pix)
                + int'(SUM_OFFSET);
            if (sum < 0) sum = 0;
            if (sum > int'(PIX_MAX)) sum = int'(PIX_MAX);
            res.edge_val   = t_pix'(sum);
            res.center_row = ROW_W'(row_pos - 1);
            res.center_col = CCOL_W'(col_pos - 1);
            expected_edges.push_back(res);
        end
        top_win[1] = top_win[0];
        top_win[0] = above2;
        mid_win[1] = mid_win[0];
        mid_win[0] = above1;
        bot_win[1] = bot_win[0];
        bot_win[0] = pix;
        upper_line[col_pos]  = above1;
        middle_line[col_pos] = pix;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_edge_result got;
        t_edge_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register_write(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                filter_pixel(i_pixel_in);
            end
            if (o_out_valid && i_out_ready) begin
                got.edge_val   = o_edge_value;
                got.center_row = o_center_row;
                got.center_col = o_center_col;
                if (expected_edges.size() == 0) begin
                    flag_error($sformatf(
                        "unexpected result: edge_value %0d center_row %0d center_col %0d",
                        got.edge_val, got.center_row, got.center_col));
                end else begin
                    want = expected_edges.pop_front();
                    if (got.edge_val !== want.edge_val) begin
                        flag_error($sformatf("edge_value mismatch: expected %0d, actual %0d",
                                             want.edge_val, got.edge_val));
                    end
                    if (got.center_row !== want.center_row) begin
                        flag_error($sformatf("center_row mismatch: expected %0d, actual %0d",
                                             want.center_row, got.center_row));
                    end
                    if (got.center_col !== want.center_col) begin
                        flag_error($sformatf("center_col mismatch: expected %0d, actual %0d",
                                             want.center_col, got.center_col));
                    end
                end
            end
        end
    end

    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                i_out_ready = quiet_mode || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_pix random_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return t_pix'($urandom_range(0, 255));
        if (pick < 7) return ($urandom_range(0, 1) != 0) ? t_pix'(PIX_MAX) : t_pix'(0);
        return t_pix'(texture_base + $urandom_range(0, 6));
    endfunction

    task automatic send_pixel(input t_pix pix);
        while (!quiet_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel_in = pix;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle_pipeline();
        int waited;
        i_in_valid = 1'b0;
        waited = 0;
        while (expected_edges.size() != 0 && waited < SETTLE_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_edges.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived",
                                 expected_edges.size()));
            expected_edges.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_reset_geometry();
        send_random_pixels(48);
        settle_pipeline();
    endtask

    task automatic test_kernel_extremes();
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i == 4) ? t_pix'(PIX_MAX) : t_pix'(0));
        end
        for (int i = 0; i < 9; i++) begin
            send_pixel((i == 4) ? t_pix'(0) : t_pix'(PIX_MAX));
        end
        settle_pipeline();
    endtask

    task automatic test_unmapped_index();
        send_random_pixels(4);
        settle_pipeline();
        write_reg(CFG_UNMAPPED_LO, '1);
        write_reg(CFG_UNMAPPED_HI, '0);
        send_random_pixels(5);
        settle_pipeline();
    endtask

    task automatic test_width_clamp_high();
        write_reg(CFG_IMAGE_WIDTH, 12'h7FF);
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_DIM));
        send_random_pixels(40);
        settle_pipeline();
    endtask

    task automatic test_height_max();
        write_reg(CFG_IMAGE_WIDTH, 12'h803);
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(HEIGHT_MAX));
        send_random_pixels(21);
        settle_pipeline();
    endtask

    task automatic test_output_stall();
        write_reg(CFG_IMAGE_WIDTH, 12'd6);
        write_reg(CFG_IMAGE_HEIGHT, 12'd5);
        hold_request = 1'b1;
        send_random_pixels(60);
        settle_pipeline();
    endtask

    task automatic test_random_frames();
        int sent;
        int phase;
        int w;
        int n;
        logic [CFG_DATA_W-1:0] width_data;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       w = $urandom_range(0, 2);
                1, 2:    w = $urandom_range(17, 40);
                default: w = $urandom_range(3, 12);
            endcase
            width_data = CFG_DATA_W'(w);
            if ($urandom_range(0, 3) == 0) width_data = width_data | 12'h800;
            case ($urandom_range(0, 5))
                0: write_reg(CFG_IMAGE_WIDTH, width_data);
                1: write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
                2: write_reg(($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
                             CFG_DATA_W'($urandom));
                default: begin
                    write_reg(CFG_IMAGE_WIDTH, width_data);
                    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(3, 8)));
                end
            endcase
            texture_base = $urandom_range(0, 249);
            quiet_mode = (phase == 2);
            n = quiet_mode ? 150 : $urandom_range(8, 150);
            send_random_pixels(n);
            sent += n;
            settle_pipeline();
            phase++;
        end
        quiet_mode = 1'b0;
    endtask

    initial begin : run_tests
        width_reg  = WIDTH_REG_W'(WIDTH_RESET);
        height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
        col_pos = 0;
        row_pos = 0;
        for (int k = 0; k < int'(MAX_WIDTH_DEF); k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (int k = 0; k < 2; k++) begin
            top_win[k] = '0;
            mid_win[k] = '0;
            bot_win[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_geometry();
        test_kernel_extremes();
        test_unmapped_index();
        test_width_clamp_high();
        test_height_max();
        test_output_stall();
        test_random_frames();

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
